@@ sv/cpst_pkg.sv @@
// types, constants and helper functions shared by the poll transaction block
// no dependencies
package cpst_pkg;

  localparam int CMD_LEN            = 9;
  localparam int MIN_RESPONSE_CHARS = 39;
  localparam int NUM_FIELDS         = 5;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  localparam logic [7:0] CMD_TEXT [7] = '{8'h52, 8'h54, 8'h3A, 8'h30, 8'h30, 8'h30, 8'h30};
  localparam logic [5:0] FIELD_START [NUM_FIELDS] = '{6'd3, 6'd7, 6'd11, 6'd15, 6'd35};

  localparam logic [5:0]  CHAR_COUNT_MAX = 6'd63;
  localparam logic [7:0]  GAP_MAX        = 8'd255;
  localparam logic [16:0] WAIT_MAX       = 17'h1FFFF;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_RX    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    KIND_TX      = 3'd0,
    KIND_COUNTS  = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_SHORT   = 3'd3,
    KIND_BUSY    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SEND = 3'b010,
    PH_RECV = 3'b100
  } phase_t;

  typedef logic [NUM_FIELDS-1:0][15:0] counters_t;

  // one group of results caused by one item
  typedef struct packed {
    logic      valid;
    kind_t     kind;
    logic [1:0] last_beat;
    logic [7:0] ch;
    counters_t counts;
  } bundle_t;

  function automatic logic [7:0] cmd_char(input logic [3:0] idx);
    logic [7:0] c;
    begin
      if (5'(idx) + 5'd1 == 5'(CMD_LEN)) c = CHAR_LF;
      else if (5'(idx) + 5'd2 == 5'(CMD_LEN)) c = CHAR_CR;
      else if (idx < 4'd7) c = CMD_TEXT[idx[2:0]];
      else c = CHAR_ZERO;
      return c;
    end
  endfunction

  function automatic logic [7:0] encode_pair(input logic [7:0] c, input logic [1:0] p);
    logic [7:0] sh;
    logic [7:0] raw;
    begin
      sh  = c >> {p, 1'b0};
      raw = IDLE_BYTE;
      raw[2] = sh[0];
      raw[5] = sh[1];
      return raw;
    end
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    begin
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else r = 5'd0;
      return r;
    end
  endfunction

endpackage

@@ sv/counter_poll_serial_transaction.sv @@
// top level of the poll transaction engine: configuration registers, core and result stage
// depends on cpst_pkg, cpst_core, cpst_out
//
// usage
//   slave beats carry a request: tuser 0 start poll, 1 millisecond tick, 2 received byte
//   (byte in tdata). a start sends the first command character as four encoded beats,
//   later characters follow ticks once the gap count is reached; then received bytes are
//   decoded and one result beat reports counters, short response or timeout.
//   a start while busy gives one busy beat. ticks while idle and stray bytes give nothing.
//   master beats: tuser is the result kind, tlast marks the final beat of one request.
//   configuration writes (index 0 timeout, 1 character gap) are taken at once and
//   should only be made while the block is idle.
// timing
//   the first result beat passes the input register and then the result register. a request
//   is worked only when the single result register is empty or its final beat is taken,
//   so the four beats of a character hold off the next request until the last one goes.
//   a request is taken while a result still waits: one request is held in the input
//   register while the master side stalls, after which tready drops.
// reset
//   synchronous; phase idle, no result pending, registers back to 5000 and 8.
module counter_poll_serial_transaction
  import cpst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // tx_byte, single_espresso, double_espresso,
                                 // coffee_count, double_coffee, cleanings
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] timeout_ms;
  logic [7:0]  char_gap_ms;
  logic        load_ok;
  bundle_t     bundle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms  <= 16'd5000;
      char_gap_ms <= 8'd8;
    end else if (cfg_valid) begin
      if (cfg_index) char_gap_ms <= cfg_data[7:0];
      else timeout_ms <= cfg_data;
    end
  end

  cpst_core u_core (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .timeout_ms  (timeout_ms),
    .char_gap_ms (char_gap_ms),
    .load_ok     (load_ok),
    .bundle      (bundle)
  );

  cpst_out u_out (
    .clk      (clk),
    .rst      (rst),
    .bundle   (bundle),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ sv/cpst_core.sv @@
// input register and transaction state: one item is worked per cycle into a result
// bundle while the result register can load; depends on cpst_pkg
module cpst_core
  import cpst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic [15:0] timeout_ms,
  input  logic [7:0]  char_gap_ms,
  input  logic        load_ok,
  output bundle_t     bundle
);

  logic       in_valid;
  logic [1:0] in_req;
  logic [7:0] in_rx;

  phase_t     phase, phase_next;
  logic [3:0] cmd_index, cmd_index_next;
  logic [7:0] gap_count, gap_count_next;
  logic [16:0] wait_count, wait_count_next;
  logic [7:0] rx_assembly, rx_assembly_next;
  logic [1:0] rx_pair_pos, rx_pair_pos_next;
  logic [7:0] prev_char, prev_char_next;
  logic [5:0] char_count, char_count_next;
  counters_t  field_accum, field_accum_next;
  logic [NUM_FIELDS-1:0] field_stopped, field_stopped_next;

  logic       work;
  logic [3:0] send_idx;
  logic [3:0] send_idx_inc;
  logic [7:0] asm_new;
  logic [4:0] hx;
  logic [6:0] pos_ext;
  logic       do_send;
  logic       recv_restart;

  assign work     = in_valid && load_ok;
  assign s_tready = !in_valid || load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_req <= s_tuser;
      in_rx  <= s_tdata;
    end
  end

  always_comb begin
    phase_next         = phase;
    cmd_index_next     = cmd_index;
    gap_count_next     = gap_count;
    wait_count_next    = wait_count;
    rx_assembly_next   = rx_assembly;
    rx_pair_pos_next   = rx_pair_pos;
    prev_char_next     = prev_char;
    char_count_next    = char_count;
    field_accum_next   = field_accum;
    field_stopped_next = field_stopped;
    do_send            = 1'b0;
    send_idx           = cmd_index;
    recv_restart       = 1'b0;
    asm_new            = rx_assembly;
    hx                 = 5'd0;
    pos_ext            = {1'b0, char_count};

    bundle           = '0;
    bundle.kind      = KIND_TX;

    unique case (in_req)
      REQ_START: begin
        if (phase != PH_IDLE) begin
          bundle.valid = 1'b1;
          bundle.kind  = KIND_BUSY;
        end else begin
          do_send  = 1'b1;
          send_idx = 4'd0;
        end
      end
      REQ_TICK: begin
        if (phase == PH_SEND) begin
          gap_count_next = (gap_count < GAP_MAX) ? gap_count + 8'd1 : gap_count;
          if (gap_count_next >= char_gap_ms) do_send = 1'b1;
        end else if (phase == PH_RECV) begin
          wait_count_next = (wait_count < WAIT_MAX) ? wait_count + 17'd1 : wait_count;
          if (wait_count_next > {1'b0, timeout_ms}) begin
            phase_next   = PH_IDLE;
            bundle.valid = 1'b1;
            bundle.kind  = KIND_TIMEOUT;
          end
        end
      end
      REQ_RX: begin
        if (phase == PH_RECV) begin
          asm_new = rx_assembly;
          if (in_rx[2]) asm_new = asm_new | (8'd1 << {rx_pair_pos, 1'b0});
          if (in_rx[5]) asm_new = asm_new | (8'd2 << {rx_pair_pos, 1'b0});
          rx_pair_pos_next = rx_pair_pos + 2'd1;
          rx_assembly_next = asm_new;
          if (rx_pair_pos_next == 2'd0) begin
            rx_assembly_next = 8'd0;
            hx = hex_value(asm_new);
            for (int i = 0; i < NUM_FIELDS; i++) begin
              if (pos_ext >= 7'(FIELD_START[i]) && pos_ext < 7'(FIELD_START[i]) + 7'd4
                  && !field_stopped[i]) begin
                if (!hx[4]) field_stopped_next[i] = 1'b1;
                else field_accum_next[i] = {field_accum[i][11:0], hx[3:0]};
              end
            end
            char_count_next = (char_count < CHAR_COUNT_MAX) ? char_count + 6'd1 : char_count;
            prev_char_next  = asm_new;
            if (prev_char == CHAR_CR && asm_new == CHAR_LF) begin
              phase_next   = PH_IDLE;
              bundle.valid = 1'b1;
              if ({1'b0, char_count_next} < 7'(MIN_RESPONSE_CHARS + 2)) begin
                bundle.kind = KIND_SHORT;
              end else begin
                bundle.kind   = KIND_COUNTS;
                bundle.counts = field_accum_next;
              end
            end
          end
        end
      end
      default: ;
    endcase

    send_idx_inc = send_idx + 4'd1;
    if (do_send) begin
      bundle.valid     = 1'b1;
      bundle.kind      = KIND_TX;
      bundle.last_beat = 2'd3;
      bundle.ch        = cmd_char(send_idx);
      phase_next       = PH_SEND;
      cmd_index_next   = send_idx_inc;
      gap_count_next   = 8'd0;
      if (5'(send_idx_inc) >= 5'(CMD_LEN)) recv_restart = 1'b1;
    end
    if (recv_restart) begin
      phase_next         = PH_RECV;
      wait_count_next    = '0;
      rx_assembly_next   = '0;
      rx_pair_pos_next   = '0;
      prev_char_next     = '0;
      char_count_next    = '0;
      field_accum_next   = '0;
      field_stopped_next = '0;
    end

    bundle.valid = bundle.valid && work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cmd_index     <= '0;
      gap_count     <= '0;
      wait_count    <= '0;
      rx_assembly   <= '0;
      rx_pair_pos   <= '0;
      prev_char     <= '0;
      char_count    <= '0;
      field_accum   <= '0;
      field_stopped <= '0;
    end else if (work) begin
      phase         <= phase_next;
      cmd_index     <= cmd_index_next;
      gap_count     <= gap_count_next;
      wait_count    <= wait_count_next;
      rx_assembly   <= rx_assembly_next;
      rx_pair_pos   <= rx_pair_pos_next;
      prev_char     <= prev_char_next;
      char_count    <= char_count_next;
      field_accum   <= field_accum_next;
      field_stopped <= field_stopped_next;
    end
  end

endmodule

@@ sv/cpst_out.sv @@
// result register: holds one bundle and hands it out one beat per cycle
// while m_tready is high; depends on cpst_pkg
module cpst_out
  import cpst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bundle_t     bundle,
  output logic        load_ok,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  logic       hold_valid;
  bundle_t    hold;
  logic [1:0] beat;
  logic       final_beat;
  logic [7:0] tx;

  assign final_beat = (beat == hold.last_beat);
  assign load_ok    = !hold_valid || (m_tready && final_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      beat       <= '0;
    end else if (load_ok) begin
      hold_valid <= bundle.valid;
      beat       <= '0;
    end else if (m_tready) begin
      beat <= beat + 2'd1;
    end
    if (load_ok) begin
      hold <= bundle;
    end
  end

  assign tx       = (hold.kind == KIND_TX) ? encode_pair(hold.ch, beat) : 8'd0;
  assign m_tvalid = hold_valid;
  assign m_tdata  = {hold.counts, tx};
  assign m_tuser  = hold.kind;
  assign m_tlast  = final_beat;

endmodule

@@ sv/cpst_checker.sv @@
// port-level checks for the poll transaction engine, bound to the top level
// depends on cpst_pkg
module cpst_checker
  import cpst_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_TX |-> m_tdata[87:8] == '0 && (m_tdata[7:0] | 8'h24) == 8'hFF)
    else $error("bad transmit beat");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_TX |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("status beat not single");

  a_tx_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == KIND_TX && !m_tlast |=> m_tvalid && m_tuser == KIND_TX)
    else $error("transmit run broken");

endmodule

bind counter_poll_serial_transaction cpst_checker u_cpst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench for counter_poll_serial_transaction: directed and random poll transactions
// checked against an in-bench prediction of command bytes, counters, short replies,
// timeouts and busy reports; depends on cpst_pkg and the block's rtl
module testbench;
  import cpst_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam logic       REG_TIMEOUT  = 1'b0;
  localparam logic       REG_CHAR_GAP = 1'b1;
  localparam int         STALL_LIMIT  = 2000;
  localparam logic [7:0] POLL_CMD [CMD_LEN] =
    '{"R", "T", ":", "0", "0", "0", "0", CHAR_CR, CHAR_LF};

  typedef struct {
    kind_t      kind;
    logic [7:0] tx;
    counters_t  counts;
    logic       is_last;
  } poll_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  counter_poll_serial_transaction dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted state of the poll engine
  logic [15:0]  timeout_reg;
  logic [7:0]   gap_reg;
  phase_t       poll_phase;
  logic [3:0]   cmd_pos;
  logic [7:0]   gap_ticks;
  logic [16:0]  wait_ticks;
  logic [7:0]   rx_shift;
  logic [1:0]   pair_pos;
  logic [7:0]   prev_reply_char;
  logic [5:0]   reply_chars;
  counters_t    field_acc;
  logic [4:0]   field_done;

  poll_result_t awaited[$];
  logic [7:0]   reply_text[$];

  int mismatches = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int kind_seen [5] = '{0, 0, 0, 0, 0};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_left = 0;
  bit send_calm = 1'b0;
  int recv_left = 0;
  bit recv_calm = 1'b0;
  int stall_cycles = 0;
  poll_result_t head;

  function automatic void emit(input kind_t k, input logic [7:0] tx, input counters_t c);
    poll_result_t r;
    r.kind = k;
    r.tx = tx;
    r.counts = c;
    r.is_last = 1'b0;
    awaited.push_back(r);
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void begin_reply();
    poll_phase = PH_RECV;
    wait_ticks = '0;
    rx_shift = '0;
    pair_pos = '0;
    prev_reply_char = '0;
    reply_chars = '0;
    field_acc = '0;
    field_done = '0;
  endfunction

  function automatic void reset_poll_model();
    timeout_reg = 16'd5000;
    gap_reg = 8'd8;
    cmd_pos = '0;
    gap_ticks = '0;
    begin_reply();
    poll_phase = PH_IDLE;
  endfunction

  function automatic void send_cmd_char();
    logic [7:0] c;
    logic [7:0] enc;
    c = POLL_CMD[cmd_pos];
    for (int p = 0; p < 4; p++) begin
      enc = IDLE_BYTE;
      enc[2] = c[2*p];
      enc[5] = c[2*p+1];
      emit(KIND_TX, enc, '0);
    end
    cmd_pos = cmd_pos + 4'd1;
    gap_ticks = '0;
    if (cmd_pos >= CMD_LEN) begin_reply();
  endfunction

  function automatic void take_reply_char(input logic [7:0] c);
    int v;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (reply_chars >= FIELD_START[i] && reply_chars < FIELD_START[i] + 6'd4 &&
          !field_done[i]) begin
        v = hex_digit(c);
        if (v < 0) field_done[i] = 1'b1;
        else field_acc[i] = {field_acc[i][11:0], 4'(v)};
      end
    end
    if (reply_chars < CHAR_COUNT_MAX) reply_chars = reply_chars + 6'd1;
    if (prev_reply_char == CHAR_CR && c == CHAR_LF) begin
      poll_phase = PH_IDLE;
      if (int'(reply_chars) - 2 < MIN_RESPONSE_CHARS) emit(KIND_SHORT, '0, '0);
      else emit(KIND_COUNTS, '0, field_acc);
    end
    prev_reply_char = c;
  endfunction

  function automatic void predict_poll(input logic [1:0] req, input logic [7:0] rx);
    int count_at_entry;
    logic [7:0] c;
    poll_result_t r;
    count_at_entry = awaited.size();
    unique case (req)
      REQ_START: begin
        if (poll_phase != PH_IDLE) begin
          emit(KIND_BUSY, '0, '0);
        end else begin
          poll_phase = PH_SEND;
          cmd_pos = '0;
          send_cmd_char();
        end
      end
      REQ_TICK: begin
        if (poll_phase == PH_SEND) begin
          if (gap_ticks < GAP_MAX) gap_ticks = gap_ticks + 8'd1;
          if (gap_ticks >= gap_reg) send_cmd_char();
        end else if (poll_phase == PH_RECV) begin
          if (wait_ticks < WAIT_MAX) wait_ticks = wait_ticks + 17'd1;
          if (wait_ticks > {1'b0, timeout_reg}) begin
            poll_phase = PH_IDLE;
            emit(KIND_TIMEOUT, '0, '0);
          end
        end
      end
      REQ_RX: begin
        if (poll_phase == PH_RECV) begin
          if (rx[2]) rx_shift[{pair_pos, 1'b0}] = 1'b1;
          if (rx[5]) rx_shift[{pair_pos, 1'b1}] = 1'b1;
          pair_pos = pair_pos + 2'd1;
          if (pair_pos == 2'd0) begin
            c = rx_shift;
            rx_shift = '0;
            take_reply_char(c);
          end
        end
      end
      default: ;
    endcase
    if (awaited.size() > count_at_entry) begin
      r = awaited.pop_back();
      r.is_last = 1'b1;
      awaited.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_checked++;
      if (m_tuser < 3'd5) kind_seen[m_tuser]++;
      if (awaited.size() == 0) begin
        report_mismatch("result beat with none awaited, kind", 32'(m_tuser), 32'd0);
      end else begin
        head = awaited.pop_front();
        if (m_tuser !== head.kind)
          report_mismatch("kind", 32'(m_tuser), 32'(head.kind));
        if (m_tdata[7:0] !== head.tx)
          report_mismatch("tx byte", 32'(m_tdata[7:0]), 32'(head.tx));
        for (int i = 0; i < NUM_FIELDS; i++)
          if (m_tdata[8+16*i +: 16] !== head.counts[i])
            report_mismatch($sformatf("counter %0d", i), 32'(m_tdata[8+16*i +: 16]),
                            32'(head.counts[i]));
        if (m_tlast !== head.is_last)
          report_mismatch("tlast", 32'(m_tlast), 32'(head.is_last));
      end
    end
  end

  always @(posedge clk) begin
    if (recv_left == 0) begin
      recv_left = $urandom_range(8, 64);
      recv_calm = ($urandom_range(3) == 0);
    end
    recv_left--;
    m_tready <= recv_calm || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, awaited.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [7:0] rx);
    int gap;
    gap = 0;
    if (send_left == 0) begin
      send_left = $urandom_range(5, 40);
      send_calm = ($urandom_range(3) == 0);
    end
    send_left--;
    if (!send_calm)
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_poll(req, rx);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    wait_for_results();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_TIMEOUT) timeout_reg = value;
    else gap_reg = value[7:0];
  endtask

  function automatic logic [1:0] noise_req(input bit with_start);
    int pick;
    pick = $urandom_range(2);
    if (pick == 0) return with_start ? REQ_START : REQ_TICK;
    if (pick == 1) return REQ_RX;
    return REQ_UNUSED;
  endfunction

  task automatic run_command(input int noise_pct);
    send_item(REQ_START, 8'($urandom));
    while (poll_phase == PH_SEND) begin
      if ($urandom_range(99) < noise_pct) send_item(noise_req(1'b1), 8'($urandom));
      else send_item(REQ_TICK, 8'($urandom));
    end
  endtask

  task automatic send_reply_char(input logic [7:0] c);
    logic [7:0] b;
    for (int p = 0; p < 4; p++) begin
      b = 8'($urandom);
      b[2] = c[2*p];
      b[5] = c[2*p+1];
      send_item(REQ_RX, b);
    end
  endtask

  task automatic send_reply(input int tick_pct);
    foreach (reply_text[i]) begin
      if ($urandom_range(99) < tick_pct) send_item(REQ_TICK, 8'($urandom));
      if (poll_phase == PH_RECV && $urandom_range(99) < tick_pct / 2)
        send_item(REQ_START, 8'($urandom));
      send_reply_char(reply_text[i]);
    end
  endtask

  function automatic void set_reply(input string s);
    reply_text.delete();
    for (int i = 0; i < s.len(); i++) reply_text.push_back(s[i]);
    reply_text.push_back(CHAR_CR);
    reply_text.push_back(CHAR_LF);
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function automatic void build_random_reply(input int len);
    reply_text.delete();
    for (int i = 0; i < len; i++) begin
      if (((i >= 3 && i < 19) || (i >= 35 && i < 39)) && $urandom_range(99) < 92)
        reply_text.push_back(random_hex_char());
      else
        reply_text.push_back(8'($urandom));
    end
    reply_text.push_back(CHAR_CR);
    reply_text.push_back(CHAR_LF);
  endfunction

  task automatic close_poll();
    while (poll_phase != PH_IDLE) send_item(REQ_TICK, 8'($urandom));
  endtask

  task automatic test_idle_requests();
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_RX, 8'h00);
    send_item(REQ_RX, 8'hFF);
    send_item(REQ_UNUSED, 8'hA5);
  endtask

  // default gap for the second character, busy and dropped bytes while sending,
  // then a full counter reply with fields cut short by non-hex characters
  task automatic test_command_default_gap();
    send_item(REQ_START, 8'h00);
    send_item(REQ_START, 8'hFF);
    send_item(REQ_RX, 8'hFF);
    send_item(REQ_UNUSED, 8'h5A);
    repeat (8) send_item(REQ_TICK, 8'($urandom));
    write_register(REG_CHAR_GAP, 16'h0000);
    while (poll_phase == PH_SEND) send_item(REQ_TICK, 8'($urandom));
    send_item(REQ_START, 8'h00);
    set_reply({"RT:", "FFFF", "a1B2", "9f:E", "g000", "0123456789abcdef", "fF0z"});
    send_reply(0);
  endtask

  task automatic test_short_reply();
    run_command(0);
    set_reply("");
    send_reply(0);
    close_poll();
  endtask

  task automatic test_timeouts();
    write_register(REG_TIMEOUT, 16'd1);
    run_command(0);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, 8'h00);
    run_command(0);
    send_item(REQ_RX, 8'hFF);
    send_item(REQ_RX, 8'h00);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, 8'h00);
  endtask

  task automatic test_gap_extremes();
    write_register(REG_CHAR_GAP, 16'hFF00);
    run_command(0);
    close_poll();
    write_register(REG_CHAR_GAP, 16'h0001);
    run_command(0);
    close_poll();
  endtask

  task automatic random_poll();
    int roll;
    if ($urandom_range(2) == 0)
      write_register(REG_CHAR_GAP, {8'($urandom), 8'($urandom_range(2))});
    if ($urandom_range(2) == 0)
      write_register(REG_TIMEOUT, 16'($urandom_range(1, 6)));
    if ($urandom_range(3) == 0) wait_for_results();
    repeat ($urandom_range(3)) send_item(noise_req(1'b0), 8'($urandom));
    run_command(10);
    roll = $urandom_range(99);
    if (roll < 50) begin
      build_random_reply($urandom_range(3));
      send_reply(5);
    end else begin
      // reply cut off part way, left to time out
      repeat ($urandom_range(1, 2)) send_reply_char(8'($urandom));
      repeat ($urandom_range(3)) send_item(REQ_RX, 8'($urandom));
    end
    close_poll();
  endtask

  task automatic test_random_polls(input int polls);
    write_register(REG_TIMEOUT, 16'd4);
    repeat (polls) random_poll();
  endtask

  task automatic test_longest_timeout();
    write_register(REG_TIMEOUT, 16'hFFFF);
    run_command(0);
    repeat (3) send_item(REQ_TICK, 8'($urandom));
    write_register(REG_TIMEOUT, 16'd2);
    close_poll();
  endtask

  initial begin
    reset_poll_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 54;
    test_idle_requests();
    test_command_default_gap();
    send_idle_pct = 54;
    recv_idle_pct = 34;
    test_short_reply();
    test_timeouts();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_gap_extremes();
    test_longest_timeout();
    test_random_polls(1);
    wait_for_results();
    repeat (20) @(posedge clk);
    $display("run covered %0d request beats and %0d result beats", items_sent, beats_checked);
    $display("command bytes %0d, counter reports %0d, timeouts %0d, short replies %0d, busy %0d",
             kind_seen[KIND_TX], kind_seen[KIND_COUNTS], kind_seen[KIND_TIMEOUT],
             kind_seen[KIND_SHORT], kind_seen[KIND_BUSY]);
    if (mismatches == 0 && awaited.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
